FILE: hw/rtl/fsc_pkg.sv
// Shared constants, types and codes for the frame sequence checker.
package fsc_pkg;

	// Frame geometry
	localparam int FRAME_LEN = 26;
	localparam int ID_OFFSET = 2;
	localparam int POS_W     = 5;

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_ID_HI = POS_W'(ID_OFFSET);
	localparam logic [POS_W-1:0] POS_ID_LO = POS_W'(ID_OFFSET + 1);

	localparam logic [7:0]  HEADER_RESET = 8'h2A;
	localparam logic [15:0] PREV_ID_RESET = 16'hFFFF;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Counter slots
	localparam int NUM_CNT     = 4;
	localparam int CNT_VALID   = 0;
	localparam int CNT_CORRUPT = 1;
	localparam int CNT_GAP     = 2;
	localparam int CNT_DUP     = 3;

	// Frame verdict codes
	typedef enum logic [2:0] {
		ST_CORRUPT = 3'd0,
		ST_FIRST   = 3'd1,
		ST_IN_SEQ  = 3'd2,
		ST_DUP     = 3'd3,
		ST_GAP     = 3'd4
	} fsc_status_t;

	// One byte of the stream as held in the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_scan;
	} fsc_byte_t;

	// Per-byte outcome from the frame core
	typedef struct packed {
		logic        frame_done;
		fsc_status_t status;
		logic [15:0] id;
		logic [31:0] valid_total;
		logic [31:0] corrupt_total;
		logic [31:0] gap_total;
		logic [31:0] duplicate_total;
	} fsc_result_t;

endpackage

FILE: hw/rtl/fsc_ifs.sv
// Valid/ready channel interfaces for the byte input and the frame result output.
interface fsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_scan;

	modport source (output valid, output data_byte, output start_of_scan, input ready);
	modport sink (input valid, input data_byte, input start_of_scan, output ready);
endinterface

interface fsc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_status;
	logic [15:0] frame_id;
	logic [31:0] valid_total;
	logic [31:0] corrupt_total;
	logic [31:0] gap_total;
	logic [31:0] duplicate_total;

	modport source (output valid, output frame_status, output frame_id,
		output valid_total, output corrupt_total, output gap_total,
		output duplicate_total, input ready);
	modport sink (input valid, input frame_status, input frame_id,
		input valid_total, input corrupt_total, input gap_total,
		input duplicate_total, output ready);
endinterface

FILE: hw/rtl/fsc_frame_core.sv
// Frame tracking state, id assembly, sequence judgment and saturating counters.
module fsc_frame_core
	import fsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  fsc_byte_t   byte_in,
	input  logic [7:0]  header_byte,
	output fsc_result_t result
);

	logic [POS_W-1:0] pos_q;
	logic             hdr_good_q;
	logic [7:0]       id_hi_q;
	logic [15:0]      id_asm_q;
	logic [15:0]      prev_id_q;
	logic             seen_valid_q;
	logic [31:0]      cnt_q [NUM_CNT];

	logic [POS_W-1:0] pos_eff;
	logic             hdr_good_eff;
	logic [15:0]      prev_id_eff;
	logic             seen_valid_eff;
	logic [31:0]      cnt_eff [NUM_CNT];

	logic [POS_W-1:0] pos_n;
	logic             hdr_good_n;
	logic [7:0]       id_hi_n;
	logic [15:0]      id_asm_n;
	logic [15:0]      prev_id_n;
	logic             seen_valid_n;
	logic [31:0]      cnt_n [NUM_CNT];
	logic             last;
	fsc_status_t      status;

	// Start of scan wipes the tracking state before the byte is used
	always_comb begin
		pos_eff        = byte_in.start_of_scan ? '0 : pos_q;
		hdr_good_eff   = byte_in.start_of_scan ? 1'b0 : hdr_good_q;
		prev_id_eff    = byte_in.start_of_scan ? PREV_ID_RESET : prev_id_q;
		seen_valid_eff = byte_in.start_of_scan ? 1'b0 : seen_valid_q;
		for (int i = 0; i < NUM_CNT; i++) begin
			cnt_eff[i] = byte_in.start_of_scan ? '0 : cnt_q[i];
		end
	end

	// Header check and big-endian id capture by byte position
	always_comb begin
		hdr_good_n = hdr_good_eff;
		id_hi_n    = id_hi_q;
		id_asm_n   = id_asm_q;
		if (pos_eff == '0) begin
			hdr_good_n = (byte_in.data_byte == header_byte);
			id_hi_n    = '0;
			id_asm_n   = '0;
		end
		if (pos_eff == POS_ID_HI) begin
			id_hi_n = byte_in.data_byte;
		end
		if (pos_eff == POS_ID_LO) begin
			id_asm_n = {id_hi_q, byte_in.data_byte};
		end
		last  = (pos_eff == POS_LAST);
		pos_n = last ? '0 : pos_eff + POS_W'(1);
	end

	// Verdict on the completed frame and counter updates
	always_comb begin
		status       = ST_CORRUPT;
		prev_id_n    = prev_id_eff;
		seen_valid_n = seen_valid_eff;
		for (int i = 0; i < NUM_CNT; i++) begin
			cnt_n[i] = cnt_eff[i];
		end
		if (last) begin
			if (!hdr_good_n) begin
				status = ST_CORRUPT;
				if (cnt_eff[CNT_CORRUPT] != CNT_MAX) begin
					cnt_n[CNT_CORRUPT] = cnt_eff[CNT_CORRUPT] + 32'd1;
				end
			end else begin
				if (!seen_valid_eff) begin
					status = ST_FIRST;
				end else if (id_asm_n == prev_id_eff) begin
					status = ST_DUP;
					if (cnt_eff[CNT_DUP] != CNT_MAX) begin
						cnt_n[CNT_DUP] = cnt_eff[CNT_DUP] + 32'd1;
					end
				end else if (id_asm_n != prev_id_eff + 16'd1) begin
					status = ST_GAP;
					if (cnt_eff[CNT_GAP] != CNT_MAX) begin
						cnt_n[CNT_GAP] = cnt_eff[CNT_GAP] + 32'd1;
					end
				end else begin
					status = ST_IN_SEQ;
				end
				prev_id_n    = id_asm_n;
				seen_valid_n = 1'b1;
				if (cnt_eff[CNT_VALID] != CNT_MAX) begin
					cnt_n[CNT_VALID] = cnt_eff[CNT_VALID] + 32'd1;
				end
			end
		end
	end

	// Result bundle seen by the output stage
	always_comb begin
		result.frame_done      = last;
		result.status          = status;
		result.id              = (status == ST_CORRUPT) ? '0 : id_asm_n;
		result.valid_total     = cnt_n[CNT_VALID];
		result.corrupt_total   = cnt_n[CNT_CORRUPT];
		result.gap_total       = cnt_n[CNT_GAP];
		result.duplicate_total = cnt_n[CNT_DUP];
	end

	// State registers, updated once per byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_good_q   <= 1'b0;
			id_hi_q      <= '0;
			id_asm_q     <= '0;
			prev_id_q    <= PREV_ID_RESET;
			seen_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (fire) begin
			pos_q        <= pos_n;
			hdr_good_q   <= hdr_good_n;
			id_hi_q      <= id_hi_n;
			id_asm_q     <= id_asm_n;
			prev_id_q    <= prev_id_n;
			seen_valid_q <= seen_valid_n;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= cnt_n[i];
			end
		end
	end

endmodule

FILE: hw/rtl/frame_sequence_checker_top.sv
// Top level of the frame sequence checker: input register, frame core, result register.
// The checker takes one stream byte per cycle while its input is not stalled
// and gives one result every FRAME_LEN bytes (26), when the last byte of a
// frame has been processed. A byte transferred in is held in the input
// register, the frame core judges it combinationally, and its result is loaded
// into the result register and visible from there, provided that register is
// free. Throughput is one byte per cycle while input is not stalled, set by
// the frame core updating its state once per byte transfer. Bytes that close
// no frame keep flowing while a result waits to be taken. A frame's last byte
// waits in the input register until the result register frees up, and input
// stalls meanwhile. header_byte resets to 0x2A; the user must write it through
// cfg_we/cfg_wdata only while the stream is idle, which the block does not
// enforce. start_of_scan on a byte clears counters, sequence history and frame
// position before that byte is taken; a partial frame then gives no result.
module frame_sequence_checker_top
	import fsc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	fsc_byte_if.sink     in_ch,
	fsc_result_if.source out_ch,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	logic [7:0]  header_q;
	logic        valid_s1;
	fsc_byte_t   byte_s1;
	fsc_result_t result;
	logic        out_valid_q;
	fsc_result_t out_q;
	logic        in_xfer;
	logic        out_free;
	logic        adv_s1;
	logic        load_out;

	// Handshake control
	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign adv_s1   = valid_s1 && (!result.frame_done || out_free);
	assign load_out = adv_s1 && result.frame_done;
	assign in_ch.ready = !valid_s1 || adv_s1;

	// Header register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1.data_byte     <= in_ch.data_byte;
			byte_s1.start_of_scan <= in_ch.start_of_scan;
		end
	end

	fsc_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv_s1),
		.byte_in     (byte_s1),
		.header_byte (header_q),
		.result      (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.frame_status    = out_q.status;
	assign out_ch.frame_id        = out_q.id;
	assign out_ch.valid_total     = out_q.valid_total;
	assign out_ch.corrupt_total   = out_q.corrupt_total;
	assign out_ch.gap_total       = out_q.gap_total;
	assign out_ch.duplicate_total = out_q.duplicate_total;

	// A stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !load_out)
		else $error("result register overwritten while stalled");

	// A held input byte is never overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !in_xfer)
		else $error("input register overwritten while held");

	// Corrupt frames carry a zero id
	a_corrupt_id: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_q.status != ST_CORRUPT || out_q.id == 16'd0))
		else $error("corrupt frame reported with nonzero id");

	// The first valid frame since a clear is the only valid one counted
	a_first_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == ST_FIRST) |->
		(out_q.valid_total == 32'd1 && out_q.gap_total == 32'd0 &&
		out_q.duplicate_total == 32'd0))
		else $error("first valid frame with inconsistent counters");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the frame sequence checker: framed byte stimulus and a checker on frame verdicts.
module tb_top;
	import fsc_pkg::*;

	localparam int RUN_LIMIT    = 200000;
	localparam int RESET_CYCLES = 12;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_STATUS   = 5;

	typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// Verdict expected for one completed frame
	typedef struct packed {
		fsc_status_t status;
		logic [15:0] id;
		logic [31:0] valid_total;
		logic [31:0] corrupt_total;
		logic [31:0] gap_total;
		logic [31:0] duplicate_total;
	} frame_verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	fsc_byte_if   in_ch ();
	fsc_result_if out_ch ();

	frame_sequence_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Stream bytes waiting for the driver, verdicts waiting for the output
	fsc_byte_t      byte_queue [$];
	frame_verdict_t verdict_q [$];

	// Frame tracker state, mirrors the block
	logic [7:0]  hdr_cfg;
	int          frm_pos;
	logic        hdr_ok;
	logic [7:0]  id_hi;
	logic [15:0] id_word;
	logic [15:0] last_id;
	logic        have_valid;
	logic [31:0] frame_tally [NUM_CNT];

	// Driver and receiver control
	int        bytes_offered;
	int        bytes_taken;
	int        burst_left;
	int        gap_left;
	logic      sender_idles;
	fsc_byte_t cur_byte;
	rx_mode_t  rx_mode;
	int        hold_left;
	logic      long_hold_req;
	logic      long_hold_done;
	logic [7:0] rx_tick;

	// Bookkeeping
	int          err_cnt;
	int          frames_checked;
	int          verdict_hist [NUM_STATUS];
	int          cycle_cnt;
	logic [15:0] gen_id;

	always #5 clk = ~clk;

	function void clear_scan();
		frm_pos    = 0;
		hdr_ok     = 1'b0;
		id_hi      = '0;
		id_word    = '0;
		last_id    = PREV_ID_RESET;
		have_valid = 1'b0;
		for (int i = 0; i < NUM_CNT; i++)
			frame_tally[i] = '0;
	endfunction

	function void bump(input int slot);
		if (frame_tally[slot] != CNT_MAX)
			frame_tally[slot] = frame_tally[slot] + 32'd1;
	endfunction

	// Advance the frame tracker by one accepted byte; queue a verdict on frame end
	function void track_byte(input logic [7:0] data, input logic sos);
		frame_verdict_t v;
		logic [15:0] next_id;
		if (sos)
			clear_scan();
		if (frm_pos == 0) begin
			hdr_ok  = (data == hdr_cfg);
			id_hi   = '0;
			id_word = '0;
		end
		if (frm_pos == ID_OFFSET)
			id_hi = data;
		if (frm_pos == ID_OFFSET + 1)
			id_word = {id_hi, data};
		if (frm_pos + 1 < FRAME_LEN) begin
			frm_pos++;
		end else begin
			frm_pos = 0;
			if (!hdr_ok) begin
				bump(CNT_CORRUPT);
				v.status = ST_CORRUPT;
				v.id     = '0;
			end else begin
				next_id = last_id + 16'd1;
				v.id    = id_word;
				if (!have_valid) begin
					v.status = ST_FIRST;
				end else if (id_word == last_id) begin
					v.status = ST_DUP;
					bump(CNT_DUP);
				end else if (id_word != next_id) begin
					v.status = ST_GAP;
					bump(CNT_GAP);
				end else begin
					v.status = ST_IN_SEQ;
				end
				last_id    = id_word;
				have_valid = 1'b1;
				bump(CNT_VALID);
			end
			v.valid_total     = frame_tally[CNT_VALID];
			v.corrupt_total   = frame_tally[CNT_CORRUPT];
			v.gap_total       = frame_tally[CNT_GAP];
			v.duplicate_total = frame_tally[CNT_DUP];
			verdict_q.push_back(v);
		end
	endfunction

	// Queue len bytes of a frame: header, big-endian id, random payload
	function void add_frame(input logic [7:0] first, input logic [15:0] fid,
		input logic sos, input int len);
		fsc_byte_t b;
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b.data_byte = first;
			else if (i == ID_OFFSET)
				b.data_byte = fid[15:8];
			else if (i == ID_OFFSET + 1)
				b.data_byte = fid[7:0];
			else
				b.data_byte = 8'($urandom_range(0, 255));
			b.start_of_scan = (i == 0) && sos;
			byte_queue.push_back(b);
		end
	endfunction

	// Mostly well-formed frames, with corrupt headers, cut frames and loose bytes mixed in
	function void gen_traffic(input int n_bytes, input logic [7:0] hdr);
		int base;
		int pick;
		int sel;
		logic need_sos;
		logic [7:0] bad;
		fsc_byte_t b;
		base = byte_queue.size();
		need_sos = 1'b1;
		while (byte_queue.size() - base < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				sel = $urandom_range(0, 99);
				if (sel < 60)
					gen_id = gen_id + 16'd1;
				else if (sel < 86 && sel >= 72)
					gen_id = 16'($urandom_range(0, 65535));
				else if (sel >= 86)
					gen_id = 16'hFFFF - 16'($urandom_range(0, 1));
				add_frame(hdr, gen_id, need_sos || ($urandom_range(0, 30) == 0), FRAME_LEN);
				need_sos = 1'b0;
			end else if (pick < 84) begin
				do
					bad = 8'($urandom_range(0, 255));
				while (bad == hdr);
				add_frame(bad, 16'($urandom_range(0, 65535)), need_sos, FRAME_LEN);
				need_sos = 1'b0;
			end else if (pick < 92) begin
				add_frame(hdr, gen_id + 16'd1, need_sos, $urandom_range(1, FRAME_LEN - 1));
				need_sos = 1'b1;
			end else begin
				repeat ($urandom_range(1, 5)) begin
					b.data_byte     = 8'($urandom_range(0, 255));
					b.start_of_scan = 1'($urandom_range(0, 1));
					byte_queue.push_back(b);
				end
				need_sos = 1'b1;
			end
		end
	endfunction

	// Wait until every byte is taken and every verdict has come back
	task drain();
		while (byte_queue.size() != 0 || bytes_taken != bytes_offered || verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task set_header(input logic [7:0] value);
		@(negedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		hdr_cfg    = value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Byte driver: bursts of random length separated by random gaps when sender_idles is set, else back-to-back bytes
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && bytes_taken < bytes_offered) begin
				// hold the current byte until its transfer
			end else if (gap_left > 0) begin
				in_ch.valid <= 1'b0;
				gap_left--;
			end else if (byte_queue.size() > 0) begin
				cur_byte = byte_queue.pop_front();
				in_ch.data_byte     <= cur_byte.data_byte;
				in_ch.start_of_scan <= cur_byte.start_of_scan;
				in_ch.valid         <= 1'b1;
				bytes_offered++;
				if (sender_idles) begin
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = $urandom_range(1, 6);
					end
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall pattern per phase, plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			rx_tick = rx_tick + 8'd1;
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD - 1;
				out_ch.ready  <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: begin
						out_ch.ready <= 1'b1;
					end
					RX_RANDOM: begin
						if ($urandom_range(0, 9) == 0) begin
							hold_left     = $urandom_range(1, 8);
							out_ch.ready <= 1'b0;
						end else begin
							out_ch.ready <= 1'($urandom_range(0, 3) != 0);
						end
					end
					default: begin
						out_ch.ready <= (rx_tick[1:0] != 2'd0) && (rx_tick[6:4] != 3'd5);
					end
				endcase
			end
		end
	end

	// Monitor: check the output transfer first, then track the input transfer
	always @(posedge clk) begin
		frame_verdict_t exp_v;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$error("result with no frame pending: status %0d id %04h",
					out_ch.frame_status, out_ch.frame_id);
				err_cnt++;
			end else begin
				exp_v = verdict_q.pop_front();
				frames_checked++;
				verdict_hist[int'(exp_v.status)]++;
				if (out_ch.frame_status !== exp_v.status) begin
					$error("frame_status: expected %0d, got %0d", exp_v.status,
						out_ch.frame_status);
					err_cnt++;
				end
				if (out_ch.frame_id !== exp_v.id) begin
					$error("frame_id: expected %04h, got %04h", exp_v.id, out_ch.frame_id);
					err_cnt++;
				end
				if (out_ch.valid_total !== exp_v.valid_total) begin
					$error("valid_total: expected %0d, got %0d", exp_v.valid_total,
						out_ch.valid_total);
					err_cnt++;
				end
				if (out_ch.corrupt_total !== exp_v.corrupt_total) begin
					$error("corrupt_total: expected %0d, got %0d", exp_v.corrupt_total,
						out_ch.corrupt_total);
					err_cnt++;
				end
				if (out_ch.gap_total !== exp_v.gap_total) begin
					$error("gap_total: expected %0d, got %0d", exp_v.gap_total,
						out_ch.gap_total);
					err_cnt++;
				end
				if (out_ch.duplicate_total !== exp_v.duplicate_total) begin
					$error("duplicate_total: expected %0d, got %0d", exp_v.duplicate_total,
						out_ch.duplicate_total);
					err_cnt++;
				end
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			track_byte(in_ch.data_byte, in_ch.start_of_scan);
			bytes_taken++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d frames still pending",
				cycle_cnt, verdict_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.data_byte     = '0;
		in_ch.start_of_scan = 1'b0;
		out_ch.ready        = 1'b0;
		bytes_offered       = 0;
		bytes_taken         = 0;
		burst_left          = 1;
		gap_left            = 0;
		sender_idles        = 1'b0;
		rx_mode             = RX_OPEN;
		hold_left           = 0;
		long_hold_req       = 1'b0;
		long_hold_done      = 1'b0;
		rx_tick             = '0;
		err_cnt             = 0;
		frames_checked      = 0;
		cycle_cnt           = 0;
		gen_id              = '0;
		for (int i = 0; i < NUM_STATUS; i++)
			verdict_hist[i] = 0;
		hdr_cfg = HEADER_RESET;
		clear_scan();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset header
		add_frame(8'h00, 16'h5555, 1'b1, FRAME_LEN);        // bad header
		add_frame(HEADER_RESET, 16'hFFFE, 1'b0, FRAME_LEN); // first good frame
		add_frame(HEADER_RESET, 16'hFFFF, 1'b0, FRAME_LEN); // in order
		add_frame(HEADER_RESET, 16'h0000, 1'b0, FRAME_LEN); // id wraps
		add_frame(HEADER_RESET, 16'h0000, 1'b0, FRAME_LEN); // repeated id
		add_frame(8'hFF, 16'h0001, 1'b0, FRAME_LEN);        // bad header, history kept
		add_frame(HEADER_RESET, 16'h0001, 1'b0, FRAME_LEN); // in order across it
		add_frame(HEADER_RESET, 16'h8000, 1'b0, FRAME_LEN); // gap
		add_frame(HEADER_RESET, 16'h8001, 1'b0, 11);        // cut off by start below
		add_frame(HEADER_RESET, 16'h7FFF, 1'b1, FRAME_LEN); // restart mid-frame
		add_frame(HEADER_RESET, 16'h7FFF, 1'b1, FRAME_LEN); // restart on a boundary
		add_frame(HEADER_RESET, 16'h8000, 1'b0, 20);        // trailing partial frame
		drain();

		// Header at its low extreme, random gaps and stalls
		set_header(8'h00);
		sender_idles = 1'b1;
		rx_mode      = RX_RANDOM;
		gen_traffic(320, 8'h00);
		drain();

		// Header at its high extreme, back-to-back bytes, patterned stalls
		set_header(8'hFF);
		sender_idles = 1'b0;
		rx_mode      = RX_PATTERN;
		gen_traffic(320, 8'hFF);
		drain();

		// Random header, long output hold-off while the stream keeps coming
		set_header(8'($urandom_range(1, 254)));
		sender_idles  = 1'b1;
		rx_mode       = RX_OPEN;
		long_hold_req = 1'b1;
		gen_traffic(370, hdr_cfg);
		drain();

		// Another random header with gaps and patterned stalls
		set_header(8'($urandom_range(0, 255)));
		sender_idles = 1'b1;
		rx_mode      = RX_PATTERN;
		gen_traffic(320, hdr_cfg);
		drain();

		$display("Sent %0d bytes, checked %0d frames: %0d corrupt, %0d first, %0d in order,",
			bytes_taken, frames_checked, verdict_hist[ST_CORRUPT], verdict_hist[ST_FIRST],
			verdict_hist[ST_IN_SEQ]);
		$display("%0d repeated, %0d gaps; five header settings, restarts, cut frames, stalls.",
			verdict_hist[ST_DUP], verdict_hist[ST_GAP]);
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
